// ===== src/ble_adv_data_parser_defines.svh =====
// Assertion macros for the BLE advertising-data parser.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BLE_ADV_DATA_PARSER_DEFINES_SVH
`define BLE_ADV_DATA_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define BLEADV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BLEADV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bleadv_pkg.sv =====
// Shared types and constants for the BLE advertising-data parser.
// No dependencies; imported by the parser top level.
package bleadv_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_UUID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKER_COMPANY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKER_TYPE    = 2'd2;

  // Register reset values
  localparam logic [15:0] RST_SERVICE_UUID    = 16'd0;
  localparam logic [15:0] RST_TRACKER_COMPANY = 16'd76;
  localparam logic [7:0]  RST_TRACKER_TYPE    = 8'd18;

  // AD record types
  localparam logic [7:0] AD_TYPE_FLAGS  = 8'h01;
  localparam logic [7:0] AD_UUID16_PART = 8'h02;
  localparam logic [7:0] AD_UUID16_FULL = 8'h03;
  localparam logic [7:0] AD_NAME_SHORT  = 8'h08;
  localparam logic [7:0] AD_NAME_FULL   = 8'h09;
  localparam logic [7:0] AD_SVC_DATA16  = 8'h16;
  localparam logic [7:0] AD_MAKER       = 8'hFF;

  // End reasons
  localparam logic [1:0] END_CLEAN     = 2'd0;
  localparam logic [1:0] END_PADDING   = 2'd1;
  localparam logic [1:0] END_TRUNCATED = 2'd2;

  // Name kinds
  localparam logic [1:0] NAME_NONE  = 2'd0;
  localparam logic [1:0] NAME_SHORT = 2'd1;
  localparam logic [1:0] NAME_FULL  = 2'd2;

  // found_mask bit positions
  localparam int unsigned FM_FLAGS   = 0;
  localparam int unsigned FM_MAKER   = 1;
  localparam int unsigned FM_TRACKER = 2;
  localparam int unsigned FM_UUID    = 3;
  localparam int unsigned FM_SVC     = 4;

  localparam logic [6:0] REC_MAX = 7'd127;

  // Record walker phase, one-hot
  typedef enum logic [3:0] {
    PH_LENGTH  = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_VALUE   = 4'b0100,
    PH_STOPPED = 4'b1000
  } phase_e;

  // Findings committed so far in the current advert
  typedef struct packed {
    logic       flags_ok;
    logic       maker_ok;
    logic       uuid_ok;
    logic       svc_ok;
    logic [7:0] flags_value;
    logic [15:0] vendor_id;
    logic [7:0] maker_offset;
    logic [7:0] maker_length;
    logic       trk_valid;
    logic [7:0] trk_byte;
    logic [7:0] svcdata_offset;
    logic [7:0] svcdata_length;
  } find_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] offset;
    logic [7:0] length;
  } name_t;

  // One result request
  typedef struct packed {
    logic [6:0]  record_count;
    logic [1:0]  end_reason;
    logic [4:0]  found_mask;
    logic [7:0]  flags_value;
    logic [15:0] vendor_id;
    logic [7:0]  maker_offset;
    logic [7:0]  maker_length;
    logic [7:0]  svcdata_offset;
    logic [7:0]  svcdata_length;
    logic [1:0]  name_kind;
    logic [7:0]  name_offset;
    logic [7:0]  name_length;
  } result_t;

endpackage

// ===== src/bleadv_ifs.sv =====
// Valid/ready channel interfaces for the BLE advertising-data parser.
// No dependencies; the byte channel feeds the parser, the result channel leaves it.
interface bleadv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bleadv_result_if;
  logic        valid;
  logic        ready;
  logic [6:0]  record_count;
  logic [1:0]  end_reason;
  logic [4:0]  found_mask;
  logic [7:0]  flags_value;
  logic [15:0] vendor_id;
  logic [7:0]  maker_offset;
  logic [7:0]  maker_length;
  logic [7:0]  svcdata_offset;
  logic [7:0]  svcdata_length;
  logic [1:0]  name_kind;
  logic [7:0]  name_offset;
  logic [7:0]  name_length;

  modport source (
    output valid, input ready,
    output record_count, output end_reason, output found_mask, output flags_value,
    output vendor_id, output maker_offset, output maker_length,
    output svcdata_offset, output svcdata_length,
    output name_kind, output name_offset, output name_length
  );
  modport sink (
    input valid, output ready,
    input record_count, input end_reason, input found_mask, input flags_value,
    input vendor_id, input maker_offset, input maker_length,
    input svcdata_offset, input svcdata_length,
    input name_kind, input name_offset, input name_length
  );
endinterface

// ===== src/ble_adv_data_parser.sv =====
// BLE advertising-data parser: walks length-type-value records one byte per cycle
// unless input stalls. A result request passes the input register, then the result
// register. Throughput: one byte per cycle while input is not stalled.
// A full result register stalls input only once the next advert's last byte arrives.
// Reset (rst_ni low, asynchronous) clears all advert state and loads register defaults.
// Depends on bleadv_pkg, bleadv_ifs and ble_adv_data_parser_defines.svh.
`include "ble_adv_data_parser_defines.svh"

module ble_adv_data_parser #(
  parameter int unsigned MAX_ADVERT_BYTES = 255
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bleadv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bleadv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  bleadv_byte_if.sink                         byte_i,
  bleadv_result_if.source                     res_o
);
  import bleadv_pkg::*;

  localparam logic [7:0] MAX_POS = 8'(MAX_ADVERT_BYTES);

  // Configuration registers
  logic [15:0] svc_uuid_q;
  logic [15:0] trk_company_q;
  logic [7:0]  trk_type_q;

  // Input register
  logic       inq_valid_q;
  logic [7:0] inq_byte_q;
  logic       inq_last_q;
  logic       adv;

  // Walker state
  phase_e      phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  vidx_q, vidx_d;
  logic [7:0]  vstart_q, vstart_d;
  logic [23:0] pend_q, pend_d;
  logic        hit_q, hit_d;
  logic [1:0]  decided_q, decided_d;
  logic [6:0]  rec_q, rec_d;
  find_t       find_q, find_d;
  name_t       name_q, name_d;

  // Result register
  logic        out_valid_q;
  result_t     res_q, res_d;

  // Advance the input register when its byte needs no result slot or the slot frees up
  assign adv = inq_valid_q && (!inq_last_q || !out_valid_q || res_o.ready);
  assign byte_i.ready = !inq_valid_q || adv;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svc_uuid_q    <= RST_SERVICE_UUID;
      trk_company_q <= RST_TRACKER_COMPANY;
      trk_type_q    <= RST_TRACKER_TYPE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SERVICE_UUID:    svc_uuid_q    <= cfg_data_i[15:0];
        CFG_TRACKER_COMPANY: trk_company_q <= cfg_data_i[15:0];
        CFG_TRACKER_TYPE:    trk_type_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming byte request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      inq_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      inq_byte_q <= byte_i.data_byte;
      inq_last_q <= byte_i.last_byte;
    end
  end

  // Walk one byte, commit a finished record, form the result on the last byte
  always_comb begin
    logic [7:0]  b;
    logic [7:0]  vlen;
    logic        is_uuid_list;
    logic [15:0] pair;
    logic [4:0]  mask;
    logic [1:0]  reason;

    b            = inq_byte_q;
    phase_d      = phase_q;
    pos_d        = pos_q;
    left_d       = left_q;
    type_d       = type_q;
    vidx_d       = vidx_q;
    vstart_d     = vstart_q;
    pend_d       = pend_q;
    hit_d        = hit_q;
    decided_d    = decided_q;
    rec_d        = rec_q;
    find_d       = find_q;
    name_d       = name_q;
    is_uuid_list = (type_q == AD_UUID16_PART) || (type_q == AD_UUID16_FULL);
    pair         = {b, pend_q[7:0]};
    vlen         = 8'd0;

    if (adv && phase_q != PH_STOPPED) begin
      if (pos_q >= MAX_POS) begin
        // Overflow: drop the byte and report truncation
        phase_d = PH_TYPE;
      end else begin
        unique case (phase_q)
          PH_LENGTH: begin
            if (b == 8'd0) begin
              phase_d = PH_STOPPED;
            end else begin
              left_d  = b;
              phase_d = PH_TYPE;
            end
          end
          PH_TYPE: begin
            type_d   = b;
            vstart_d = pos_q + 8'd1;
            vidx_d   = 8'd0;
            pend_d   = 24'd0;
            hit_d    = 1'b0;
            left_d   = left_q - 8'd1;
            phase_d  = PH_VALUE;
          end
          PH_VALUE: begin
            if (is_uuid_list) begin
              if (!vidx_q[0]) begin
                pend_d[7:0] = b;
              end else if (pair == svc_uuid_q) begin
                hit_d = 1'b1;
              end
            end else if (vidx_q < 8'd3) begin
              case (vidx_q[1:0])
                2'd0:    pend_d[7:0]   = b;
                2'd1:    pend_d[15:8]  = b;
                default: pend_d[23:16] = b;
              endcase
            end
            vidx_d = vidx_q + 8'd1;
            left_d = left_q - 8'd1;
          end
          default: ;
        endcase

        // Commit the record on its last byte
        if (phase_d == PH_VALUE && left_d == 8'd0) begin
          vlen    = vidx_d;
          phase_d = PH_LENGTH;
          if (rec_q != REC_MAX) begin
            rec_d = rec_q + 7'd1;
          end
          if (type_d == AD_TYPE_FLAGS && !decided_q[0]) begin
            decided_d[0] = 1'b1;
            if (vlen >= 8'd1) begin
              find_d.flags_ok    = 1'b1;
              find_d.flags_value = pend_d[7:0];
            end
          end else if (type_d == AD_MAKER && !decided_q[1]) begin
            decided_d[1] = 1'b1;
            if (vlen >= 8'd2) begin
              find_d.maker_ok     = 1'b1;
              find_d.vendor_id    = pend_d[15:0];
              find_d.maker_length = vlen - 8'd2;
              find_d.maker_offset = (vlen > 8'd2) ? (vstart_d + 8'd2) : 8'd0;
              find_d.trk_valid    = (vlen >= 8'd3);
              find_d.trk_byte     = pend_d[23:16];
            end
          end else if (type_d == AD_UUID16_PART || type_d == AD_UUID16_FULL) begin
            if (hit_d) begin
              find_d.uuid_ok = 1'b1;
            end
          end else if (type_d == AD_SVC_DATA16) begin
            if (!find_q.svc_ok && vlen >= 8'd2 && pend_d[15:0] == svc_uuid_q) begin
              find_d.svc_ok         = 1'b1;
              find_d.svcdata_length = vlen - 8'd2;
              find_d.svcdata_offset = (vlen > 8'd2) ? (vstart_d + 8'd2) : 8'd0;
            end
          end else if (vlen != 8'd0) begin
            if (type_d == AD_NAME_FULL && name_q.kind != NAME_FULL) begin
              name_d.kind   = NAME_FULL;
              name_d.offset = vstart_d;
              name_d.length = vlen;
            end else if (type_d == AD_NAME_SHORT && name_q.kind == NAME_NONE) begin
              name_d.kind   = NAME_SHORT;
              name_d.offset = vstart_d;
              name_d.length = vlen;
            end
          end
        end
        pos_d = pos_q + 8'd1;
      end
    end

    // Form the result from the state after this byte
    if (phase_d == PH_LENGTH) begin
      reason = END_CLEAN;
    end else if (phase_d == PH_STOPPED) begin
      reason = END_PADDING;
    end else begin
      reason = END_TRUNCATED;
    end
    mask              = 5'd0;
    mask[FM_FLAGS]    = find_d.flags_ok;
    mask[FM_MAKER]    = find_d.maker_ok;
    mask[FM_TRACKER]  = find_d.maker_ok && find_d.vendor_id == trk_company_q &&
                        find_d.trk_valid && find_d.trk_byte == trk_type_q;
    mask[FM_UUID]     = find_d.uuid_ok;
    mask[FM_SVC]      = find_d.svc_ok;

    res_d.record_count   = rec_d;
    res_d.end_reason     = reason;
    res_d.found_mask     = mask;
    res_d.flags_value    = find_d.flags_value;
    res_d.vendor_id      = find_d.vendor_id;
    res_d.maker_offset   = find_d.maker_offset;
    res_d.maker_length   = find_d.maker_length;
    res_d.svcdata_offset = find_d.svcdata_offset;
    res_d.svcdata_length = find_d.svcdata_length;
    res_d.name_kind      = name_d.kind;
    res_d.name_offset    = name_d.offset;
    res_d.name_length    = name_d.length;

    // Clear advert state after the last byte
    if (adv && inq_last_q) begin
      phase_d   = PH_LENGTH;
      pos_d     = 8'd0;
      left_d    = 8'd0;
      type_d    = 8'd0;
      vidx_d    = 8'd0;
      vstart_d  = 8'd0;
      pend_d    = 24'd0;
      hit_d     = 1'b0;
      decided_d = 2'd0;
      rec_d     = 7'd0;
      find_d    = '0;
      name_d    = '0;
    end
  end

  // Walker state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LENGTH;
      pos_q     <= 8'd0;
      left_q    <= 8'd0;
      type_q    <= 8'd0;
      vidx_q    <= 8'd0;
      vstart_q  <= 8'd0;
      pend_q    <= 24'd0;
      hit_q     <= 1'b0;
      decided_q <= 2'd0;
      rec_q     <= 7'd0;
      find_q    <= '0;
      name_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      left_q    <= left_d;
      type_q    <= type_d;
      vidx_q    <= vidx_d;
      vstart_q  <= vstart_d;
      pend_q    <= pend_d;
      hit_q     <= hit_d;
      decided_q <= decided_d;
      rec_q     <= rec_d;
      find_q    <= find_d;
      name_q    <= name_d;
    end
  end

  // Result register: load on the last byte, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && inq_last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && inq_last_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.record_count   = res_q.record_count;
  assign res_o.end_reason     = res_q.end_reason;
  assign res_o.found_mask     = res_q.found_mask;
  assign res_o.flags_value    = res_q.flags_value;
  assign res_o.vendor_id      = res_q.vendor_id;
  assign res_o.maker_offset   = res_q.maker_offset;
  assign res_o.maker_length   = res_q.maker_length;
  assign res_o.svcdata_offset = res_q.svcdata_offset;
  assign res_o.svcdata_length = res_q.svcdata_length;
  assign res_o.name_kind      = res_q.name_kind;
  assign res_o.name_offset    = res_q.name_offset;
  assign res_o.name_length    = res_q.name_length;

  // Checks
  `BLEADV_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, adv && inq_last_q,
    out_valid_q, "last byte did not raise a result")
  `BLEADV_ASSERT_NEXT(a_last_clears_advert, clk_i, rst_ni, adv && inq_last_q,
    phase_q == PH_LENGTH && pos_q == 8'd0 && rec_q == 7'd0 && decided_q == 2'd0,
    "advert state not cleared after last byte")
  `BLEADV_ASSERT_NOW(a_pos_bounds, clk_i, rst_ni, pos_q == 8'd0,
    rec_q == 7'd0 && name_q.kind == NAME_NONE, "findings present at position zero")
  `BLEADV_ASSERT_NOW(a_pos_cap, clk_i, rst_ni, 1'b1, pos_q <= MAX_POS,
    "byte position ran past the advert limit")

endmodule
